@@ hdl/lz_rle_bitstream_decompressor_core_assert.svh @@
// assertion macros used by the decompressor rtl (lzrle_dec)
`ifndef LZ_RLE_BITSTREAM_DECOMPRESSOR_CORE_ASSERT_SVH
`define LZ_RLE_BITSTREAM_DECOMPRESSOR_CORE_ASSERT_SVH
`ifndef SYNTH
`define LZR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lzrle assertion failed");
`define LZR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lzrle assertion failed");
`else
`define LZR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LZR_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ hdl/lzrle_pkg.sv @@
`default_nettype none
package lzrle_pkg;

  // token phases of the bitstream parser
  typedef enum logic [4:0] {
    PH_ESC, PH_LIT, PH_LEN, PH_POSHI, PH_EXTRA, PH_POSLO, PH_ADD, PH_ADDPOS,
    PH_SEL1, PH_SHORTPOS, PH_SEL2, PH_NEWESC, PH_ESCLIT, PH_RLELEN, PH_RLELO,
    PH_RLEHI, PH_CODE, PH_CODELO, PH_COPY, PH_RUN
  } phase_t;

  // sequencer states
  typedef enum logic [1:0] {ST_IDLE, ST_STEP, ST_RDWAIT, ST_EMIT} ctrl_t;

  // result status codes
  localparam logic [1:0] STAT_BYTE = 2'd0;
  localparam logic [1:0] STAT_NEED = 2'd1;
  localparam logic [1:0] STAT_DONE = 2'd2;
  localparam logic [1:0] STAT_DERR = 2'd3;

  // input opcodes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

  // register indexes
  localparam logic [2:0] REG_INIT_ESC = 3'd0;
  localparam logic [2:0] REG_ESC_W    = 3'd1;
  localparam logic [2:0] REG_GAMMA    = 3'd2;
  localparam logic [2:0] REG_XBITS    = 3'd3;
  localparam logic [2:0] REG_TBL_A    = 3'd4;
  localparam logic [2:0] REG_TBL_B    = 3'd5;
  localparam logic [2:0] REG_TBL_C    = 3'd6;
  localparam logic [2:0] REG_TBL_D    = 3'd7;

  localparam logic [7:0] CODE_BASE = 8'd32;

  typedef struct packed {
    logic       opcode;
    logic [7:0] packed_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [3:0]   escape_width;
    logic [2:0]   gamma_limit;
    logic [2:0]   extra_bits;
    logic [255:0] run_table;
  } dec_cfg_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } dec_res_t;

endpackage
`default_nettype wire

@@ hdl/lzrle_ifs.sv @@
`default_nettype none
// input transaction channel
interface lzrle_in_if;
  logic                valid;
  logic                ready;
  lzrle_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// result transaction channel
interface lzrle_out_if;
  logic                 valid;
  logic                 ready;
  lzrle_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/lzrle_ram.sv @@
`default_nettype none
module lzrle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end
endmodule
`default_nettype wire

@@ hdl/lzrle_dec.sv @@
`default_nettype none
module lzrle_dec #(
  parameter int DEPTH = 65536
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lzrle_pkg::dec_cfg_t cfg,
  input  wire logic                esc_load,
  input  wire logic [7:0]          esc_init,
  input  wire logic                in_valid,
  input  wire lzrle_pkg::in_item_t in_item,
  output logic                     in_ready,
  output lzrle_pkg::dec_res_t      res,
  input  wire logic                res_ready
);
  import lzrle_pkg::*;
  `include "lz_rle_bitstream_decompressor_core_assert.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int VW = $clog2(DEPTH + 1);
  localparam int XW = 22;

  ctrl_t       st_r, st_nxt;
  phase_t      ph_r, ph_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [3:0]  bl_r, bl_nxt;
  logic [7:0]  esc_r, esc_nxt;
  logic [7:0]  acc_r, acc_nxt;
  logic [3:0]  fc_r, fc_nxt;
  logic [2:0]  gc_r, gc_nxt;
  logic        sfx_r, sfx_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [19:0] dist_r, dist_nxt;
  logic [7:0]  add_r, add_nxt;
  logic [7:0]  run_r, run_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [VW-1:0] vc_r, vc_nxt;
  logic        fin_r, fin_nxt;
  out_item_t   res_r, res_nxt;

  logic [3:0]  ew, n_need, fn;
  logic [2:0]  xb, gl;
  logic        is_gamma, is_sel, have_bit, bit_in;
  logic [7:0]  gv, v8, ve, put_data, rd_data, tb;
  logic [4:0]  tk;
  logic [8:0]  endc, pw;
  logic [19:0] dn;
  logic [20:0] dp1;
  logic        start, put, step_emit, rd_req;
  logic [AW-1:0] rd_addr;
  logic [XW-1:0] rawd;

  // clamped configuration
  assign ew = (cfg.escape_width > 4'd8) ? 4'd8 : cfg.escape_width;
  assign xb = (cfg.extra_bits > 3'd4) ? 3'd4 : cfg.extra_bits;
  assign gl = cfg.gamma_limit;
  assign have_bit = (bl_r != 4'd0);
  assign bit_in = hold_r[7];
  assign gv = (8'd1 << gc_r) | acc_r;
  assign endc = (9'd2 << gl) - 9'd2;
  assign pw = 9'd1 << gl;
  assign tk = v8[4:0] - 5'd1;
  assign tb = (v8 == 8'd0) ? 8'd0 : cfg.run_table[{tk, 3'b000} +: 8];

  // history read address, wraps below zero
  assign rawd = XW'(wp_r) - XW'(dist_r) - XW'(1);
  assign rd_addr = rawd[XW-1] ? AW'(rawd + XW'(DEPTH)) : AW'(rawd);

  // field width of the current phase
  always_comb begin
    is_gamma = 1'b0;
    is_sel = 1'b0;
    n_need = 4'd8;
    case (ph_r)
      PH_ESC, PH_NEWESC: n_need = ew;
      PH_LIT, PH_ESCLIT: n_need = 4'd8 - ew;
      PH_EXTRA:          n_need = {1'b0, xb};
      PH_RLELO:          n_need = 4'd8 - {1'b0, gl};
      PH_CODELO:         n_need = 4'd3;
      PH_LEN, PH_POSHI, PH_RLELEN, PH_RLEHI, PH_CODE: is_gamma = 1'b1;
      PH_SEL1, PH_SEL2:  is_sel = 1'b1;
      default:           n_need = 4'd8;
    endcase
  end
  assign fn = is_gamma ? {1'b0, gc_r} : n_need;
  assign v8 = is_gamma ? gv : acc_r;
  assign ve = (ew == 4'd0) ? esc_r : v8;

  lzrle_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_hist (
    .clk(clk), .wr_en(put), .wr_addr(wp_r), .wr_data(put_data),
    .rd_en(rd_req), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  // parser datapath, one bit or one decision per cycle while in ST_STEP
  always_comb begin
    ph_nxt = ph_r; hold_nxt = hold_r; bl_nxt = bl_r; esc_nxt = esc_r;
    acc_nxt = acc_r; fc_nxt = fc_r; gc_nxt = gc_r; sfx_nxt = sfx_r;
    rem_nxt = rem_r; dist_nxt = dist_r; add_nxt = add_r; run_nxt = run_r;
    fin_nxt = fin_r; res_nxt = res_r;
    step_emit = 1'b0; rd_req = 1'b0; put = 1'b0; put_data = 8'd0;
    start = 1'b0; dn = dist_r;
    case (st_r)
      ST_IDLE: begin
        if (in_valid && in_item.opcode == OP_PUSH && !fin_r && bl_r == 4'd0) begin
          hold_nxt = in_item.packed_byte;
          bl_nxt = 4'd8;
        end
        if (in_valid && in_item.opcode == OP_PULL) begin
          res_nxt = '{plain_byte: 8'd0, status: STAT_DONE};
        end
      end
      ST_STEP: begin
        if (ph_r == PH_COPY || ph_r == PH_RUN) begin
          if (rem_r == 17'd0) begin
            ph_nxt = PH_ESC;
          end else begin
            rem_nxt = rem_r - 17'd1;
            if (rem_r == 17'd1) ph_nxt = PH_ESC;
            if (ph_r == PH_COPY) begin
              rd_req = 1'b1;
            end else begin
              put = 1'b1; put_data = run_r; step_emit = 1'b1;
              res_nxt = '{plain_byte: run_r, status: STAT_BYTE};
            end
          end
        end else if (is_sel || (is_gamma && !sfx_r && gc_r < gl) ||
                     (!(is_gamma && !sfx_r) && fc_r < fn)) begin
          // a bit is needed
          if (!have_bit) begin
            step_emit = 1'b1;
            res_nxt = '{plain_byte: 8'd0, status: STAT_NEED};
          end else begin
            hold_nxt = {hold_r[6:0], 1'b0};
            bl_nxt = bl_r - 4'd1;
            if (is_sel) begin
              if (ph_r == PH_SEL1) ph_nxt = bit_in ? PH_SEL2 : PH_SHORTPOS;
              else ph_nxt = bit_in ? PH_RLELEN : PH_NEWESC;
            end else if (is_gamma && !sfx_r) begin
              if (bit_in) gc_nxt = gc_r + 3'd1;
              else sfx_nxt = 1'b1;
            end else begin
              acc_nxt = {acc_r[6:0], bit_in};
              fc_nxt = fc_r + 4'd1;
            end
          end
        end else if (is_gamma && !sfx_r) begin
          // prefix reached the limit
          sfx_nxt = 1'b1;
        end else begin
          // field complete
          acc_nxt = 8'd0; fc_nxt = 4'd0;
          if (is_gamma) begin
            gc_nxt = 3'd0; sfx_nxt = 1'b0;
          end
          case (ph_r)
            PH_ESC: begin
              if (ve == esc_r) ph_nxt = PH_LEN;
              else begin
                run_nxt = ve; ph_nxt = PH_LIT;
              end
            end
            PH_LIT: begin
              put = 1'b1; put_data = (run_r << (4'd8 - ew)) | v8;
              ph_nxt = PH_ESC; step_emit = 1'b1;
              res_nxt = '{plain_byte: put_data, status: STAT_BYTE};
            end
            PH_LEN: begin
              rem_nxt = {9'd0, v8};
              ph_nxt = (v8 != 8'd1) ? PH_POSHI : PH_SEL1;
            end
            PH_POSHI: begin
              if ({1'b0, v8 - 8'd1} == endc) begin
                if (rem_r > 17'd3) ph_nxt = PH_ADD;
                else begin
                  fin_nxt = 1'b1; rem_nxt = 17'd0; ph_nxt = PH_ESC; step_emit = 1'b1;
                  res_nxt = '{plain_byte: 8'd0, status: STAT_DONE};
                end
              end else begin
                dist_nxt = {12'd0, v8 - 8'd1};
                ph_nxt = (xb != 3'd0) ? PH_EXTRA : PH_POSLO;
              end
            end
            PH_EXTRA: begin
              dist_nxt = (dist_r << xb) | {12'd0, v8};
              ph_nxt = PH_POSLO;
            end
            PH_POSLO: begin
              dn = {dist_r[11:0], ~v8};
              add_nxt = 8'd0; start = 1'b1;
            end
            PH_ADD: begin
              add_nxt = v8; ph_nxt = PH_ADDPOS;
            end
            PH_ADDPOS, PH_SHORTPOS: begin
              dn = {12'd0, ~v8};
              if (ph_r == PH_SHORTPOS) add_nxt = 8'd0;
              start = 1'b1;
            end
            PH_NEWESC: begin
              run_nxt = v8; ph_nxt = PH_ESCLIT;
            end
            PH_ESCLIT: begin
              put = 1'b1; put_data = (esc_r << (4'd8 - ew)) | v8;
              esc_nxt = run_r; ph_nxt = PH_ESC; step_emit = 1'b1;
              res_nxt = '{plain_byte: put_data, status: STAT_BYTE};
            end
            PH_RLELEN: begin
              if ({1'b0, v8} >= pw) begin
                rem_nxt = 17'({1'b0, v8} - pw); ph_nxt = PH_RLELO;
              end else begin
                rem_nxt = {9'd0, v8}; ph_nxt = PH_CODE;
              end
            end
            PH_RLELO: begin
              rem_nxt = (rem_r << (4'd8 - {1'b0, gl})) | {9'd0, v8};
              ph_nxt = PH_RLEHI;
            end
            PH_RLEHI: begin
              rem_nxt = {1'b0, rem_r[15:8] | (v8 - 8'd1), rem_r[7:0]};
              ph_nxt = PH_CODE;
            end
            PH_CODE: begin
              if (v8 < CODE_BASE) begin
                run_nxt = tb; rem_nxt = rem_r + 17'd1; ph_nxt = PH_RUN;
              end else begin
                run_nxt = v8 - CODE_BASE; ph_nxt = PH_CODELO;
              end
            end
            PH_CODELO: begin
              run_nxt = {run_r[4:0], v8[2:0]};
              rem_nxt = rem_r + 17'd1; ph_nxt = PH_RUN;
            end
            default: ph_nxt = PH_ESC;
          endcase
          // distance check at copy start
          if (start) begin
            dist_nxt = dn;
            if (dp1 > 21'(vc_r)) begin
              fin_nxt = 1'b1; rem_nxt = 17'd0; ph_nxt = PH_ESC; step_emit = 1'b1;
              res_nxt = '{plain_byte: 8'd0, status: STAT_DERR};
            end else begin
              rem_nxt = rem_r + 17'd1; ph_nxt = PH_COPY;
            end
          end
        end
      end
      ST_RDWAIT: begin
        put = 1'b1; put_data = rd_data + add_r;
        res_nxt = '{plain_byte: put_data, status: STAT_BYTE};
      end
      default: ;
    endcase
    if (esc_load) esc_nxt = esc_init;
  end
  assign dp1 = {1'b0, dn} + 21'd1;

  // write pointer and fill count
  always_comb begin
    wp_nxt = wp_r;
    vc_nxt = vc_r;
    if (put) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      if (vc_r < VW'(DEPTH)) vc_nxt = vc_r + VW'(1);
    end
  end

  // sequencer next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:   if (in_valid && in_item.opcode == OP_PULL) st_nxt = fin_r ? ST_EMIT : ST_STEP;
      ST_STEP:   if (step_emit) st_nxt = ST_EMIT; else if (rd_req) st_nxt = ST_RDWAIT;
      ST_RDWAIT: st_nxt = ST_EMIT;
      ST_EMIT:   if (res_ready) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = (st_r == ST_IDLE);
    res.valid = (st_r == ST_EMIT);
    res.item = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ph_r <= PH_ESC; hold_r <= 8'd0; bl_r <= 4'd0;
      esc_r <= 8'd0; acc_r <= 8'd0; fc_r <= 4'd0; gc_r <= 3'd0; sfx_r <= 1'b0;
      rem_r <= 17'd0; dist_r <= 20'd0; add_r <= 8'd0; run_r <= 8'd0;
      wp_r <= '0; vc_r <= '0; fin_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ph_r <= ph_nxt; hold_r <= hold_nxt; bl_r <= bl_nxt;
      esc_r <= esc_nxt; acc_r <= acc_nxt; fc_r <= fc_nxt; gc_r <= gc_nxt;
      sfx_r <= sfx_nxt; rem_r <= rem_nxt; dist_r <= dist_nxt; add_r <= add_nxt;
      run_r <= run_nxt; wp_r <= wp_nxt; vc_r <= vc_nxt; fin_r <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  `LZR_ASSERT_IMP(a_bits_held, clk, rst_n, 1'b1, bl_r <= 4'd8)
  `LZR_ASSERT_NXT(a_fin_sticky, clk, rst_n, fin_r, fin_r)
  `LZR_ASSERT_NXT(a_read_emits, clk, rst_n, st_r == ST_RDWAIT, st_r == ST_EMIT)
  `LZR_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, vc_r <= VW'(DEPTH))
endmodule
`default_nettype wire

@@ hdl/lz_rle_bitstream_decompressor_core.sv @@
// a push transaction is taken while the core is idle; a pull steps the parser through
//   each stream bit consumed and each parsed field, passes ST_RDWAIT for a history
//   copy, then emits from ST_EMIT into the result register
// each stream bit and each parsed field takes its own parser step
// one transaction is in flight at a time; the result register frees the core
// reset: synchronous active low, clears parser state and loads default registers
`default_nettype none
module lz_rle_bitstream_decompressor_core #(
  parameter int HISTORY_DEPTH = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  lzrle_in_if.sink         in_ch,
  lzrle_out_if.source      out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready
);
  import lzrle_pkg::*;

  logic [7:0]  init_esc_r;
  logic [3:0]  ew_r;
  logic [2:0]  gl_r;
  logic [2:0]  xb_r;
  logic [63:0] tbl_r [4];
  logic        wr_stb;
  logic [2:0]  ridx;
  dec_cfg_t    cfg;
  dec_res_t    res;
  logic        res_ready;
  logic        ovalid_r;
  out_item_t   oitem_r;

  // register write strobe
  assign pready = 1'b1;
  assign wr_stb = psel && penable && pwrite;
  assign ridx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_esc_r <= 8'd0; ew_r <= 4'd2; gl_r <= 3'd7; xb_r <= 3'd0;
      tbl_r[0] <= 64'd0; tbl_r[1] <= 64'd0; tbl_r[2] <= 64'd0; tbl_r[3] <= 64'd0;
    end else if (wr_stb) begin
      case (ridx)
        REG_INIT_ESC: init_esc_r <= pwdata[7:0];
        REG_ESC_W:    ew_r <= pwdata[3:0];
        REG_GAMMA:    gl_r <= pwdata[2:0];
        REG_XBITS:    xb_r <= pwdata[2:0];
        REG_TBL_A:    tbl_r[0] <= pwdata;
        REG_TBL_B:    tbl_r[1] <= pwdata;
        REG_TBL_C:    tbl_r[2] <= pwdata;
        REG_TBL_D:    tbl_r[3] <= pwdata;
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (ridx)
      REG_INIT_ESC: prdata = {56'd0, init_esc_r};
      REG_ESC_W:    prdata = {60'd0, ew_r};
      REG_GAMMA:    prdata = {61'd0, gl_r};
      REG_XBITS:    prdata = {61'd0, xb_r};
      REG_TBL_A:    prdata = tbl_r[0];
      REG_TBL_B:    prdata = tbl_r[1];
      REG_TBL_C:    prdata = tbl_r[2];
      REG_TBL_D:    prdata = tbl_r[3];
      default:      prdata = 64'd0;
    endcase
  end

  assign cfg = '{escape_width: ew_r, gamma_limit: gl_r, extra_bits: xb_r,
                 run_table: {tbl_r[3], tbl_r[2], tbl_r[1], tbl_r[0]}};

  lzrle_dec #(.DEPTH(HISTORY_DEPTH)) u_dec (
    .clk(clk), .rst_n(rst_n), .cfg(cfg),
    .esc_load(wr_stb && ridx == REG_INIT_ESC), .esc_init(pwdata[7:0]),
    .in_valid(in_ch.valid), .in_item(in_ch.data), .in_ready(in_ch.ready),
    .res(res), .res_ready(res_ready)
  );

  // result output register
  assign res_ready = !ovalid_r || out_ch.ready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (res_ready) begin
      ovalid_r <= res.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      oitem_r <= res.item;
    end
  end
  assign out_ch.valid = ovalid_r;
  assign out_ch.data = oitem_r;
endmodule
`default_nettype wire
